// File: rtl/core/srl_pkg.sv
// Shared types and constants for the sorted record list.
// Used by every module of the block; no dependencies of its own.
package srl_pkg;

    localparam int CAPACITY_DEF = 32;
    localparam int KEY_W        = 32;
    localparam int GRADE_W      = 16;
    localparam int TAG_W        = 16;
    localparam int OP_W         = 3;
    localparam int STATUS_W     = 2;
    localparam int TOTAL_W      = 6;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT    = 3'd0,
        OP_RM_FIRST  = 3'd1,
        OP_RM_LAST   = 3'd2,
        OP_RM_KEY    = 3'd3,
        OP_LOOKUP    = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [GRADE_W-1:0]      grade;
        logic [TAG_W-1:0]        name_tag;
    } rec_t;

    // Control that the top level broadcasts to every cell of the row.
    typedef struct packed {
        logic cmp_en;
        logic upd_ins;
        logic upd_rm_first;
        logic upd_rm_key;
    } cell_cmd_t;

endpackage

// File: rtl/core/sorted_record_list_top.sv
// Top level of the sorted record list: control, count and the row of cells.
// Depends on srl_pkg and srl_cell.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_ready  | op, key, grade, name_tag
//  out     | output    | out_valid/out_ready| status, found_key, found_grade,
//          |           |                    | found_name_tag, entry_total
//
// A transaction is accepted in the idle state: every cell then compares its key
// with the incoming key and registers the result; in the update state the whole
// row shifts or holds at once. A result waits in an output register; the next
// transaction is accepted meanwhile, but its update cycle stalls until that result has been taken.
// Reset clears the count, the flags and the control; the records need no clearing.
module sorted_record_list_top
#(
    parameter int CAPACITY = srl_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [srl_pkg::OP_W-1:0]            op,
    input  logic signed [srl_pkg::KEY_W-1:0]    key,
    input  logic [srl_pkg::GRADE_W-1:0]         grade,
    input  logic [srl_pkg::TAG_W-1:0]           name_tag,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [srl_pkg::STATUS_W-1:0]        status,
    output logic signed [srl_pkg::KEY_W-1:0]    found_key,
    output logic [srl_pkg::GRADE_W-1:0]         found_grade,
    output logic [srl_pkg::TAG_W-1:0]           found_name_tag,
    output logic [srl_pkg::TOTAL_W-1:0]         entry_total
);
    import srl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        S_IDLE,
        S_UPD
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [OP_W-1:0]   op_reg;
    rec_t              new_rec_reg;
    logic              out_valid_reg;
    status_t           status_reg;
    status_t           status_next;
    rec_t              found_reg;
    rec_t              found_next;

    cell_cmd_t         cmd;
    rec_t              cell_rec  [CAPACITY];
    logic [CAPACITY-1:0] less_vec;
    logic [CAPACITY-1:0] match_vec;
    logic [CAPACITY-1:0] left_less_vec;
    logic [CAPACITY-1:0] occ_vec;
    logic [CAPACITY-1:0] first_vec;
    rec_t              hit_rec;

    logic              accept;
    logic              out_free;
    logic              commit;
    logic              empty;
    logic              full;
    logic              found;
    logic [CNT_W+TOTAL_W-1:0] count_ext;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign commit   = (state_reg == S_UPD) && out_free;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(CAPACITY));
    assign found = |match_vec;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_row
            rec_t left_rec;
            rec_t right_rec;

            assign occ_vec[gi] = (CNT_W'(gi) < count_reg);

            if (gi == 0)
            begin : g_head
                assign left_less_vec[gi] = 1'b1;
                assign left_rec          = new_rec_reg;
            end
            else
            begin : g_body
                assign left_less_vec[gi] = less_vec[gi-1];
                assign left_rec          = cell_rec[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_rec = cell_rec[gi];
            end
            else
            begin : g_inner
                assign right_rec = cell_rec[gi+1];
            end

            // Keys are sorted, so the first match is the one whose left neighbor is smaller.
            assign first_vec[gi] = match_vec[gi] && left_less_vec[gi];

            srl_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .cmp_key   (key),
                .occ       (occ_vec[gi]),
                .new_rec   (new_rec_reg),
                .left_rec  (left_rec),
                .right_rec (right_rec),
                .left_less (left_less_vec[gi]),
                .rec       (cell_rec[gi]),
                .less      (less_vec[gi]),
                .match     (match_vec[gi])
            );
        end
    endgenerate

    always_comb
    begin
        hit_rec = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (first_vec[i])
            begin
                hit_rec = hit_rec | cell_rec[i];
            end
        end
    end

    always_comb
    begin
        cmd              = '0;
        cmd.cmp_en       = accept;
        count_next       = count_reg;
        status_next      = ST_OK;
        found_next       = '0;
        case (op_reg)
            OP_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.upd_ins = commit;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_RM_FIRST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.upd_rm_first = commit;
                    count_next       = count_reg - CNT_W'(1);
                end
            end
            OP_RM_LAST:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_RM_KEY:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    cmd.upd_rm_key = commit;
                    count_next     = count_reg - CNT_W'(1);
                end
            end
            OP_LOOKUP:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    found_next = hit_rec;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
            found_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    if (commit)
                    begin
                        state_reg     <= S_IDLE;
                        count_reg     <= count_next;
                        out_valid_reg <= 1'b1;
                        status_reg    <= status_next;
                        found_reg     <= found_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg               <= op;
            new_rec_reg.key      <= key;
            new_rec_reg.grade    <= grade;
            new_rec_reg.name_tag <= name_tag;
        end
    end

    assign count_ext      = (CNT_W+TOTAL_W)'(count_reg);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_key      = found_reg.key;
    assign found_grade    = found_reg.grade;
    assign found_name_tag = found_reg.name_tag;
    assign entry_total    = count_ext[TOTAL_W-1:0];

endmodule

// File: rtl/core/srl_cell.sv
// One cell of the record row: holds one record and its compare flags.
// Depends on srl_pkg for the record and command types.
module srl_cell
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  srl_pkg::cell_cmd_t              cmd,
    input  logic signed [srl_pkg::KEY_W-1:0] cmp_key,
    input  logic                            occ,
    input  srl_pkg::rec_t                   new_rec,
    input  srl_pkg::rec_t                   left_rec,
    input  srl_pkg::rec_t                   right_rec,
    input  logic                            left_less,
    output srl_pkg::rec_t                   rec,
    output logic                            less,
    output logic                            match
);
    import srl_pkg::*;

    rec_t rec_reg;
    rec_t rec_next;
    logic less_reg;
    logic match_reg;

    always_comb
    begin
        rec_next = rec_reg;
        if (cmd.upd_ins)
        begin
            // The new record lands where the less-than flags change from one to zero;
            // everything from there on moves one place toward the tail.
            if (left_less && !less_reg)
            begin
                rec_next = new_rec;
            end
            else if (!left_less)
            begin
                rec_next = left_rec;
            end
        end
        else if (cmd.upd_rm_first)
        begin
            rec_next = right_rec;
        end
        else if (cmd.upd_rm_key && !less_reg)
        begin
            rec_next = right_rec;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            less_reg  <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (cmd.cmp_en)
        begin
            less_reg  <= occ && (rec_reg.key < cmp_key);
            match_reg <= occ && (rec_reg.key == cmp_key);
        end
    end

    assign rec   = rec_reg;
    assign less  = less_reg;
    assign match = match_reg;

endmodule

// File: rtl/core/srl_checker.sv
// Port-level checks for the sorted record list, bound to the top level.
// Depends on srl_pkg for the status codes.
module srl_checker
#(
    parameter int CAPACITY = srl_pkg::CAPACITY_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [srl_pkg::STATUS_W-1:0]        status,
    input  logic signed [srl_pkg::KEY_W-1:0]    found_key,
    input  logic [srl_pkg::GRADE_W-1:0]         found_grade,
    input  logic [srl_pkg::TAG_W-1:0]           found_name_tag,
    input  logic [srl_pkg::TOTAL_W-1:0]         entry_total
);
    import srl_pkg::*;

    // A waiting result's status and count must hold until the result is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_total))
        else $error("result changed while stalled");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_FULL) |-> entry_total == TOTAL_W'(CAPACITY))
        else $error("full status with a list that is not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_EMPTY) |-> entry_total == '0)
        else $error("empty status with records held");

    // Found fields are only ever filled by a successful lookup.
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((found_key != '0) || (found_grade != '0) || (found_name_tag != '0))
        |-> status == ST_OK && entry_total != '0)
        else $error("record reported without a successful lookup");

endmodule

bind sorted_record_list_top srl_checker #(.CAPACITY(CAPACITY)) u_srl_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .found_key      (found_key),
    .found_grade    (found_grade),
    .found_name_tag (found_name_tag),
    .entry_total    (entry_total)
);
